/* rtl/cbe_pkg.sv */
// ----------------------------------------------------------------------------
// Cubic B-spline evaluator package
// Shared widths, payload structs, queue entry and sequencer state types, and
// the fixed-point helpers used by the evaluation datapath.
// ----------------------------------------------------------------------------
package cbe_pkg;

    localparam int DATA_W        = 32;
    localparam int FRAC_BITS     = 16;
    localparam int INDEX_W       = 10;
    localparam int TABLE_DEPTH   = 1024;
    localparam int CNT_W         = 10;
    localparam int SPLINE_DEGREE = 3;
    localparam int WINDOW_KNOTS  = 7;
    localparam int WIN_LEN       = WINDOW_KNOTS + 1;
    localparam int QUEUE_DEPTH   = 2;

    // Product of two Q values after the fraction is dropped, and the accumulator.
    localparam int PQ_W  = 2 * DATA_W - FRAC_BITS;
    localparam int ACC_W = PQ_W + 4;
    // Magnitude of a ratio dividend: 33-bit difference shifted up by the fraction.
    localparam int DIFF_W = DATA_W + 1;
    localparam int DVD_W  = DIFF_W + FRAC_BITS;

    localparam logic [1:0] MODE_KNOT = 2'd0;
    localparam logic [1:0] MODE_COEF = 2'd1;
    localparam logic [1:0] MODE_EVAL = 2'd2;

    typedef struct packed {
        logic [1:0]               mode;
        logic [INDEX_W-1:0]       table_index;
        logic signed [DATA_W-1:0] data_value;
    } req_t;

    typedef struct packed {
        logic signed [DATA_W-1:0] spline_value;
        logic                     in_range;
    } rsp_t;

    typedef enum logic [1:0] {
        OP_KNOT,
        OP_COEF,
        OP_EVAL
    } op_t;

    typedef struct packed {
        op_t                      op;
        logic [INDEX_W-1:0]       index;
        logic signed [DATA_W-1:0] data;
    } qent_t;

    typedef struct packed {
        logic                     start;
        logic signed [DIFF_W-1:0] num;
        logic signed [DIFF_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                     done;
        logic signed [DATA_W-1:0] quo;
    } div_rsp_t;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_SR_FIRST,
        BK_SR_SCAN,
        BK_WIN,
        BK_BASE,
        BK_TERM_RD,
        BK_DIV_SET,
        BK_DIV,
        BK_MUL,
        BK_TRUNC,
        BK_COMB,
        BK_COEF_RD,
        BK_COEF_MUL,
        BK_COEF_ACC,
        BK_OUT
    } bk_state_t;

    // Clamp a wide signed value to the 32-bit signed range.
    function automatic logic signed [DATA_W-1:0] sat_word(input logic signed [ACC_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v[ACC_W-1:DATA_W-1] == '0 || v[ACC_W-1:DATA_W-1] == '1) begin
            r = v[DATA_W-1:0];
        end
        else if (v[ACC_W-1]) begin
            r = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else begin
            r = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return r;
    endfunction

    // Drop the fraction of a Q product, rounding toward zero.
    function automatic logic signed [PQ_W-1:0] trunc_q(input logic signed [2*DATA_W-1:0] p);
        logic signed [2*DATA_W-1:0] b;
        b = p + (p[2*DATA_W-1] ? ((2*DATA_W)'(1) << FRAC_BITS) - (2*DATA_W)'(1)
                               : (2*DATA_W)'(0));
        return b[2*DATA_W-1:FRAC_BITS];
    endfunction

    function automatic logic signed [ACC_W-1:0] ext_pq(input logic signed [PQ_W-1:0] v);
        return {{(ACC_W-PQ_W){v[PQ_W-1]}}, v};
    endfunction

endpackage

/* rtl/cbe_front.sv */
// ----------------------------------------------------------------------------
// Request front end
// Accepts requests, drops those that do nothing, and turns the rest into
// queue entries for the back end.
// ----------------------------------------------------------------------------
module cbe_front (
    input  logic          req_valid,
    output logic          req_stall,
    input  cbe_pkg::req_t req,
    input  logic          queue_full,
    output logic          push,
    output cbe_pkg::qent_t ent
);
    import cbe_pkg::*;

    logic keep;

    always_comb
    begin
        ent.index = req.table_index;
        ent.data  = req.data_value;
        ent.op    = OP_EVAL;
        keep      = 1'b0;
        unique case (req.mode)
            MODE_KNOT:
            begin
                ent.op = OP_KNOT;
                keep   = (int'(req.table_index) < TABLE_DEPTH);
            end
            MODE_COEF:
            begin
                ent.op = OP_COEF;
                keep   = (int'(req.table_index) < TABLE_DEPTH);
            end
            MODE_EVAL:
            begin
                ent.op = OP_EVAL;
                keep   = 1'b1;
            end
            default:
            begin
                keep = 1'b0;
            end
        endcase
    end

    assign req_stall = queue_full;
    assign push      = req_valid && !queue_full && keep;

endmodule

/* rtl/cbe_queue.sv */
// ----------------------------------------------------------------------------
// Request queue
// Short first-in first-out buffer between the front end and the back end.
// ----------------------------------------------------------------------------
module cbe_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  cbe_pkg::qent_t push_ent,
    input  logic           pop,
    output cbe_pkg::qent_t head,
    output logic           nonempty,
    output logic           full
);
    import cbe_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CQ_W  = $clog2(QUEUE_DEPTH + 1);

    qent_t            ent_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CQ_W-1:0]  count_reg, count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (int'(p) == QUEUE_DEPTH - 1) begin
            r = '0;
        end
        else begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign head     = ent_reg[rd_ptr_reg];
    assign nonempty = (count_reg != '0);
    assign full     = (count_reg == CQ_W'(QUEUE_DEPTH));

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg + CQ_W'(push) - CQ_W'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= push_ent;
        end
    end

endmodule

/* rtl/cbe_divider.sv */
// ----------------------------------------------------------------------------
// Ratio divider
// Radix-2 restoring divider for (num * 2^F) / den, truncating toward zero and
// saturating to 32 bits signed. One quotient bit per cycle.
// ----------------------------------------------------------------------------
module cbe_divider (
    input  logic              clk,
    input  logic              rst_n,
    input  cbe_pkg::div_req_t dreq,
    output cbe_pkg::div_rsp_t drsp
);
    import cbe_pkg::*;

    localparam int CNT_DW = $clog2(DVD_W + 1);

    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [CNT_DW-1:0] cnt_reg, cnt_next;
    logic [DVD_W-1:0]  dvd_reg, dvd_next;
    logic [DIFF_W-1:0] dvs_reg, dvs_next;
    logic [DIFF_W:0]   rem_reg, rem_next;
    logic [DVD_W-1:0]  quo_reg, quo_next;
    logic              neg_reg, neg_next;

    logic [DIFF_W-1:0] num_abs, den_abs;
    logic [DIFF_W:0]   rem_sh;
    logic              big;
    logic [DATA_W-1:0] mag;

    always_comb
    begin
        num_abs = dreq.num[DIFF_W-1] ? (~dreq.num + DIFF_W'(1)) : dreq.num;
        den_abs = dreq.den[DIFF_W-1] ? (~dreq.den + DIFF_W'(1)) : dreq.den;
        rem_sh  = {rem_reg[DIFF_W-1:0], dvd_reg[DVD_W-1]};

        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        neg_next  = neg_reg;

        if (dreq.start) begin
            busy_next = 1'b1;
            cnt_next  = CNT_DW'(DVD_W);
            dvd_next  = {num_abs, {FRAC_BITS{1'b0}}};
            dvs_next  = den_abs;
            rem_next  = '0;
            quo_next  = '0;
            neg_next  = dreq.num[DIFF_W-1] ^ dreq.den[DIFF_W-1];
        end
        else if (busy_reg) begin
            dvd_next = {dvd_reg[DVD_W-2:0], 1'b0};
            if (rem_sh >= {1'b0, dvs_reg}) begin
                rem_next = rem_sh - {1'b0, dvs_reg};
                quo_next = {quo_reg[DVD_W-2:0], 1'b1};
            end
            else begin
                rem_next = rem_sh;
                quo_next = {quo_reg[DVD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - CNT_DW'(1);
            if (cnt_reg == CNT_DW'(1)) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end

        // Any magnitude of 2^31 or more clamps; -2^31 lands on the minimum as well.
        big = (quo_reg[DVD_W-1:DATA_W-1] != '0);
        mag = quo_reg[DATA_W-1:0];
        drsp.done = done_reg;
        if (big) begin
            drsp.quo = neg_reg ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
        end
        else begin
            drsp.quo = neg_reg ? (~mag + DATA_W'(1)) : mag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        neg_reg <= neg_next;
    end

endmodule

/* rtl/cbe_back.sv */
// ----------------------------------------------------------------------------
// Evaluation back end
// Holds the knot and coefficient memories, executes table loads, and runs the
// interval search and the bottom-up Cox-de Boor recursion for evaluations.
// ----------------------------------------------------------------------------
module cbe_back (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic [cbe_pkg::CNT_W-1:0]   interval_count,
    input  cbe_pkg::qent_t              head,
    input  logic                        nonempty,
    output logic                        pop,
    output logic                        rsp_valid,
    input  logic                        rsp_stall,
    output cbe_pkg::rsp_t               rsp
);
    import cbe_pkg::*;

    localparam logic [INDEX_W:0] DEPTH_X = (INDEX_W+1)'(TABLE_DEPTH);

    bk_state_t state_reg, state_next;

    logic [DATA_W-1:0]        knot_mem [TABLE_DEPTH];
    logic [DATA_W-1:0]        coef_mem [TABLE_DEPTH];
    logic signed [DATA_W-1:0] knot_rdata, coef_rdata;
    logic                     knot_we, coef_we;
    logic [INDEX_W-1:0]       knot_raddr, coef_raddr;

    logic signed [DATA_W-1:0] x_reg, x_next;
    logic [INDEX_W-1:0]       n_reg, n_next;
    logic [INDEX_W-1:0]       midx_reg, midx_next;
    logic [1:0]               nterm_reg, nterm_next;
    logic signed [DATA_W-1:0] prev_reg, prev_next;
    logic [3:0]               wj_reg, wj_next;
    logic                     wv_reg, wv_next;
    logic signed [DATA_W-1:0] win_reg [WIN_LEN];
    logic signed [DATA_W-1:0] win_next [WIN_LEN];
    logic signed [DATA_W-1:0] cur_reg [WIN_LEN];
    logic signed [DATA_W-1:0] cur_next [WIN_LEN];
    logic [1:0]               k_reg, k_next;
    logic [2:0]               i_reg, i_next;
    logic                     h_reg, h_next;
    logic [1:0]               j_reg, j_next;
    logic signed [DATA_W-1:0] lo_reg, lo_next;
    logic signed [DATA_W-1:0] hi_reg, hi_next;
    logic signed [DATA_W-1:0] bas_reg, bas_next;
    logic signed [DATA_W-1:0] q_reg, q_next;
    logic signed [2*DATA_W-1:0] prod_reg, prod_next;
    logic signed [PQ_W-1:0]   c1_reg, c1_next;
    logic signed [PQ_W-1:0]   c2_reg, c2_next;
    logic signed [ACC_W-1:0]  acc_reg, acc_next;
    logic                     found_reg, found_next;
    logic                     rsp_valid_reg, rsp_valid_next;
    rsp_t                     rsp_reg, rsp_next;

    div_req_t                 dreq;
    div_rsp_t                 drsp;

    logic [INDEX_W:0]         n_plus;
    logic                     scan_more;
    logic                     match;
    logic [INDEX_W-1:0]       midx_c;
    logic [INDEX_W:0]         waddr_sum;
    logic [2:0]               a_idx, b_idx;
    logic [3:0]               b_sum;
    logic                     last_i;
    logic signed [DATA_W-1:0] mul_a, mul_b;
    logic                     out_free;

    cbe_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .dreq  (dreq),
        .drsp  (drsp)
    );

    always_ff @(posedge clk)
    begin
        if (knot_we) begin
            knot_mem[head.index] <= head.data;
        end
        knot_rdata <= knot_mem[knot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (coef_we) begin
            coef_mem[head.index] <= head.data;
        end
        coef_rdata <= coef_mem[coef_raddr];
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= BK_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg     <= x_next;
        n_reg     <= n_next;
        midx_reg  <= midx_next;
        nterm_reg <= nterm_next;
        prev_reg  <= prev_next;
        wj_reg    <= wj_next;
        wv_reg    <= wv_next;
        win_reg   <= win_next;
        cur_reg   <= cur_next;
        k_reg     <= k_next;
        i_reg     <= i_next;
        h_reg     <= h_next;
        j_reg     <= j_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        bas_reg   <= bas_next;
        q_reg     <= q_next;
        prod_reg  <= prod_next;
        c1_reg    <= c1_next;
        c2_reg    <= c2_next;
        acc_reg   <= acc_next;
        found_reg <= found_next;
        rsp_reg   <= rsp_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        x_next         = x_reg;
        n_next         = n_reg;
        midx_next      = midx_reg;
        nterm_next     = nterm_reg;
        prev_next      = prev_reg;
        wj_next        = wj_reg;
        wv_next        = wv_reg;
        win_next       = win_reg;
        cur_next       = cur_reg;
        k_next         = k_reg;
        i_next         = i_reg;
        h_next         = h_reg;
        j_next         = j_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        bas_next       = bas_reg;
        q_next         = q_reg;
        prod_next      = prod_reg;
        c1_next        = c1_reg;
        c2_next        = c2_reg;
        acc_next       = acc_reg;
        found_next     = found_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = rsp_stall ? rsp_valid_reg : 1'b0;

        pop        = 1'b0;
        knot_we    = 1'b0;
        coef_we    = 1'b0;
        knot_raddr = '0;
        coef_raddr = '0;
        dreq.start = 1'b0;
        dreq.num   = '0;
        dreq.den   = '0;
        out_free   = !rsp_valid_reg || !rsp_stall;

        n_plus    = {1'b0, n_reg} + (INDEX_W+1)'(1);
        scan_more = (n_plus < {1'b0, interval_count}) && ((n_plus + (INDEX_W+1)'(1)) < DEPTH_X);
        match     = (x_reg >= prev_reg) && (x_reg < knot_rdata);
        midx_c    = (int'(n_reg) > SPLINE_DEGREE) ? (n_reg - INDEX_W'(SPLINE_DEGREE)) : '0;
        waddr_sum = {1'b0, midx_reg} + (INDEX_W+1)'(wj_reg);
        a_idx     = i_reg + 3'(h_reg);
        b_sum     = 4'(i_reg) + 4'(k_reg) + 4'(h_reg);
        b_idx     = b_sum[2:0];
        last_i    = ((4'(i_reg) + 4'(k_reg)) == 4'(WIN_LEN - 2));
        mul_a     = (state_reg == BK_COEF_MUL) ? coef_rdata : q_reg;
        mul_b     = (state_reg == BK_COEF_MUL) ? cur_reg[j_reg] : bas_reg;

        unique case (state_reg)
            BK_IDLE:
            begin
                if (nonempty) begin
                    pop = 1'b1;
                    unique case (head.op)
                        OP_KNOT: knot_we = 1'b1;
                        OP_COEF: coef_we = 1'b1;
                        OP_EVAL:
                        begin
                            x_next     = head.data;
                            n_next     = '0;
                            acc_next   = '0;
                            found_next = 1'b0;
                            knot_raddr = '0;
                            if (interval_count == '0) begin
                                state_next = BK_OUT;
                            end
                            else begin
                                state_next = BK_SR_FIRST;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            BK_SR_FIRST:
            begin
                prev_next  = knot_rdata;
                knot_raddr = INDEX_W'(1);
                state_next = BK_SR_SCAN;
            end
            BK_SR_SCAN:
            begin
                // prev_reg holds knot[n], the read data holds knot[n+1].
                if (match) begin
                    found_next = 1'b1;
                    midx_next  = midx_c;
                    nterm_next = 2'(n_reg - midx_c);
                    wj_next    = '0;
                    state_next = BK_WIN;
                end
                else if (scan_more) begin
                    n_next     = n_plus[INDEX_W-1:0];
                    prev_next  = knot_rdata;
                    knot_raddr = INDEX_W'(n_plus + (INDEX_W+1)'(1));
                end
                else begin
                    state_next = BK_OUT;
                end
            end
            BK_WIN:
            begin
                knot_raddr = waddr_sum[INDEX_W-1:0];
                wv_next    = (waddr_sum < DEPTH_X);
                if (wj_reg != 4'd0) begin
                    win_next[3'(wj_reg - 4'd1)] = wv_reg ? knot_rdata : '0;
                end
                wj_next = wj_reg + 4'd1;
                if (wj_reg == 4'(WIN_LEN)) begin
                    state_next = BK_BASE;
                end
            end
            BK_BASE:
            begin
                for (int t = 0; t < WIN_LEN - 1; t++) begin
                    cur_next[t] = (x_reg >= win_reg[t] && x_reg < win_reg[t+1])
                                  ? DATA_W'(1) << FRAC_BITS : '0;
                end
                cur_next[WIN_LEN-1] = '0;
                k_next     = 2'd1;
                i_next     = '0;
                h_next     = 1'b0;
                state_next = BK_TERM_RD;
            end
            BK_TERM_RD:
            begin
                lo_next    = win_reg[a_idx];
                hi_next    = win_reg[b_idx];
                bas_next   = cur_reg[a_idx];
                state_next = BK_DIV_SET;
            end
            BK_DIV_SET:
            begin
                // A zero knot span drops this half of the recursion term.
                if (hi_reg == lo_reg) begin
                    if (!h_reg) begin
                        c1_next    = '0;
                        h_next     = 1'b1;
                        state_next = BK_TERM_RD;
                    end
                    else begin
                        c2_next    = '0;
                        state_next = BK_COMB;
                    end
                end
                else begin
                    dreq.start = 1'b1;
                    dreq.num   = h_reg ? ($signed({hi_reg[DATA_W-1], hi_reg})
                                          - $signed({x_reg[DATA_W-1], x_reg}))
                                       : ($signed({x_reg[DATA_W-1], x_reg})
                                          - $signed({lo_reg[DATA_W-1], lo_reg}));
                    dreq.den   = $signed({hi_reg[DATA_W-1], hi_reg})
                               - $signed({lo_reg[DATA_W-1], lo_reg});
                    state_next = BK_DIV;
                end
            end
            BK_DIV:
            begin
                if (drsp.done) begin
                    q_next     = drsp.quo;
                    state_next = BK_MUL;
                end
            end
            BK_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = BK_TRUNC;
            end
            BK_TRUNC:
            begin
                if (!h_reg) begin
                    c1_next    = trunc_q(prod_reg);
                    h_next     = 1'b1;
                    state_next = BK_TERM_RD;
                end
                else begin
                    c2_next    = trunc_q(prod_reg);
                    state_next = BK_COMB;
                end
            end
            BK_COMB:
            begin
                cur_next[i_reg] = sat_word(ext_pq(c1_reg) + ext_pq(c2_reg));
                h_next = 1'b0;
                if (last_i) begin
                    if (int'(k_reg) == SPLINE_DEGREE) begin
                        j_next     = '0;
                        state_next = BK_COEF_RD;
                    end
                    else begin
                        k_next     = k_reg + 2'd1;
                        i_next     = '0;
                        state_next = BK_TERM_RD;
                    end
                end
                else begin
                    i_next     = i_reg + 3'd1;
                    state_next = BK_TERM_RD;
                end
            end
            BK_COEF_RD:
            begin
                coef_raddr = midx_reg + INDEX_W'(j_reg);
                state_next = BK_COEF_MUL;
            end
            BK_COEF_MUL:
            begin
                prod_next  = mul_a * mul_b;
                state_next = BK_COEF_ACC;
            end
            BK_COEF_ACC:
            begin
                acc_next = acc_reg + ext_pq(trunc_q(prod_reg));
                if (j_reg == nterm_reg) begin
                    state_next = BK_OUT;
                end
                else begin
                    j_next     = j_reg + 2'd1;
                    state_next = BK_COEF_RD;
                end
            end
            BK_OUT:
            begin
                if (out_free) begin
                    rsp_next.spline_value = sat_word(acc_reg);
                    rsp_next.in_range     = found_reg;
                    rsp_valid_next        = 1'b1;
                    state_next            = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
    end

endmodule

/* rtl/cubic_bspline_evaluator_core.sv */
// ----------------------------------------------------------------------------
// Cubic B-spline evaluator core
// Loads knot and coefficient tables and evaluates a cubic B-spline at a point.
// ----------------------------------------------------------------------------
// Requests arrive on req (valid/stall): mode 0 writes knot[table_index],
// mode 1 writes coefficient[table_index], mode 2 evaluates at data_value and
// returns one result on rsp (valid/stall). Mode 3 is accepted and dropped.
// The front end classifies each request into a two-entry queue; the back end
// takes one entry at a time. A table write is done as its entry is popped.
// An evaluation scans the intervals (one knot read per cycle), then runs up
// to 30 ratio divisions of the recursion, each on a 49-step serial divider
// followed by one multiply and one truncation, and last sums up to four
// coefficient products.
// Results leave through an output register, so a stalled receiver holds the
// result while the queue keeps taking requests until it fills. Reset empties
// the queue, drops any result and sets interval_count to 1. The tables are not
// cleared: entries read before they are written are undefined. The user must
// write interval_count on APB only while idle; the block does not enforce it.
// ----------------------------------------------------------------------------
module cubic_bspline_evaluator_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_stall,
    input  cbe_pkg::req_t req,
    output logic          rsp_valid,
    input  logic          rsp_stall,
    output cbe_pkg::rsp_t rsp,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready
);
    import cbe_pkg::*;

    logic [CNT_W-1:0] interval_count_reg, interval_count_next;
    logic             cfg_write;

    logic             push, pop, q_full, q_nonempty;
    qent_t            push_ent, head;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == 1'b0);
    assign prdata    = (paddr[2] == 1'b0) ? 32'(interval_count_reg) : '0;

    always_comb
    begin
        interval_count_next = cfg_write ? pwdata[CNT_W-1:0] : interval_count_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            interval_count_reg <= CNT_W'(1);
        end
        else begin
            interval_count_reg <= interval_count_next;
        end
    end

    cbe_front u_front (
        .req_valid  (req_valid),
        .req_stall  (req_stall),
        .req        (req),
        .queue_full (q_full),
        .push       (push),
        .ent        (push_ent)
    );

    cbe_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_ent (push_ent),
        .pop      (pop),
        .head     (head),
        .nonempty (q_nonempty),
        .full     (q_full)
    );

    cbe_back u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .interval_count (interval_count_reg),
        .head           (head),
        .nonempty       (q_nonempty),
        .pop            (pop),
        .rsp_valid      (rsp_valid),
        .rsp_stall      (rsp_stall),
        .rsp            (rsp)
    );

endmodule

/* rtl/cbe_checker.sv */
// ----------------------------------------------------------------------------
// Port checker
// Watches the evaluator's ports and flags result and register misbehavior.
// ----------------------------------------------------------------------------
module cbe_checker (
    input logic          clk,
    input logic          rst_n,
    input logic          rsp_valid,
    input logic          rsp_stall,
    input cbe_pkg::rsp_t rsp,
    input logic          psel,
    input logic          penable,
    input logic          pwrite,
    input logic [2:0]    paddr,
    input logic [31:0]   pwdata,
    input logic [31:0]   prdata
);
    import cbe_pkg::*;

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result changed or vanished");

    a_out_of_range_zero: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp.in_range |-> rsp.spline_value == '0)
        else $error("out-of-range result is not zero");

    a_reg_readback: assert property (@(posedge clk) disable iff (!rst_n)
        psel && penable && pwrite && paddr[2] == 1'b0 ##1 paddr[2] == 1'b0
        |-> prdata == {22'd0, $past(pwdata[9:0])})
        else $error("interval count readback differs from the last write");

    a_reg_upper_zero: assert property (@(posedge clk) disable iff (!rst_n)
        prdata[31:10] == '0)
        else $error("register read shows bits above the count");

endmodule

bind cubic_bspline_evaluator_core cbe_checker u_cbe_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata)
);
